FILE: src/double_ended_priority_queue_core_assert.svh
// ----------------------------------------------------------------------------
// double-ended priority queue assertion macros
// shared property forms for the port checker
// ----------------------------------------------------------------------------
`ifndef DOUBLE_ENDED_PRIORITY_QUEUE_CORE_ASSERT_SVH
`define DOUBLE_ENDED_PRIORITY_QUEUE_CORE_ASSERT_SVH

// same-cycle implication, disabled in reset
`define DEP_ASSERT_NOW(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("dep assertion failed");

// next-cycle implication, disabled in reset
`define DEP_ASSERT_NEXT(label, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("dep assertion failed");

`endif

FILE: src/dep_pkg.sv
// ----------------------------------------------------------------------------
// dep_pkg
// commands, status codes and cell control for the double-ended queue
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package dep_pkg;

    localparam int unsigned DATA_W   = 32;
    localparam int unsigned CMD_W    = 3;
    localparam int unsigned STATUS_W = 2;
    localparam int unsigned COUNT_W  = 7;

    typedef enum logic [CMD_W-1:0] {
        CMD_INSERT  = 3'd0,
        CMD_EXT_MIN = 3'd1,
        CMD_EXT_MAX = 3'd2,
        CMD_PEEK_MIN = 3'd3,
        CMD_PEEK_MAX = 3'd4,
        CMD_SIZE    = 3'd5,
        CMD_CLEAR   = 3'd6
    } cmd_t;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK    = 2'd0,
        ST_EMPTY = 2'd1,
        ST_FULL  = 2'd2
    } status_t;

    // one operation per cycle for every cell of a chain
    typedef struct packed {
        logic ins;
        logic shift_down;
        logic drop_top;
        logic clr;
    } cell_ctrl_t;

endpackage

`default_nettype wire

FILE: src/double_ended_priority_queue_core.sv
// ----------------------------------------------------------------------------
// double_ended_priority_queue_core
// double-ended priority queue of signed 32-bit values on two cell chains
// ----------------------------------------------------------------------------
// A request is taken at any clock edge with start high; busy stays low, so a
// new request may follow in every cycle. Each request gives one result on the
// next cycle, marked by done for that single cycle; the receiver has no way
// to hold it, so it must capture status, result_value and count when done is
// high. Every command, insert and extract too, ends before the next request:
// the elements sit in two rows of CAPACITY cells, one ascending and one
// descending, that shift in parallel, so the minimum and maximum are always
// at the heads. After reset the queue is empty and usable at once.
`timescale 1ns / 1ps
`default_nettype none

module double_ended_priority_queue_core #(
    parameter int unsigned CAPACITY = 64
) (
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                start,
    output logic                                     busy,
    input  wire logic [dep_pkg::CMD_W-1:0]           command,
    input  wire logic signed [dep_pkg::DATA_W-1:0]   value,
    output logic                                     done,
    output logic [dep_pkg::STATUS_W-1:0]             status,
    output logic signed [dep_pkg::DATA_W-1:0]        result_value,
    output logic [dep_pkg::COUNT_W-1:0]              count
);
    import dep_pkg::*;

    localparam int unsigned CW = $clog2(CAPACITY + 1);

    cell_ctrl_t               asc_ctrl;
    cell_ctrl_t               desc_ctrl;
    logic signed [DATA_W-1:0] min_value;
    logic signed [DATA_W-1:0] max_value;
    logic                     not_empty;
    logic                     full;
    logic                     accept;

    logic [CW-1:0]            count_reg;
    logic [CW-1:0]            count_next;
    logic                     done_reg;
    logic [STATUS_W-1:0]      status_reg;
    logic [STATUS_W-1:0]      status_next;
    logic signed [DATA_W-1:0] result_reg;
    logic signed [DATA_W-1:0] result_next;

    assign busy   = 1'b0;
    assign accept = start && !busy;

    always_comb
    begin
        asc_ctrl    = '0;
        desc_ctrl   = '0;
        count_next  = count_reg;
        status_next = ST_OK;
        result_next = '0;
        if (accept)
        begin
            case (cmd_t'(command))
                CMD_INSERT:
                begin
                    if (full)
                    begin
                        status_next = ST_FULL;
                    end
                    else
                    begin
                        asc_ctrl.ins  = 1'b1;
                        desc_ctrl.ins = 1'b1;
                        count_next    = count_reg + CW'(1);
                    end
                end
                CMD_EXT_MIN:
                begin
                    if (!not_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        result_next          = min_value;
                        asc_ctrl.shift_down  = 1'b1;
                        desc_ctrl.drop_top   = 1'b1;
                        count_next           = count_reg - CW'(1);
                    end
                end
                CMD_EXT_MAX:
                begin
                    if (!not_empty)
                    begin
                        status_next = ST_EMPTY;
                    end
                    else
                    begin
                        result_next          = max_value;
                        desc_ctrl.shift_down = 1'b1;
                        asc_ctrl.drop_top    = 1'b1;
                        count_next           = count_reg - CW'(1);
                    end
                end
                CMD_PEEK_MIN:
                begin
                    if (!not_empty)
                        status_next = ST_EMPTY;
                    else
                        result_next = min_value;
                end
                CMD_PEEK_MAX:
                begin
                    if (!not_empty)
                        status_next = ST_EMPTY;
                    else
                        result_next = max_value;
                end
                CMD_SIZE:
                begin
                    status_next = ST_OK;
                end
                CMD_CLEAR:
                begin
                    asc_ctrl.clr  = 1'b1;
                    desc_ctrl.clr = 1'b1;
                    count_next    = '0;
                end
                default:
                begin
                    status_next = ST_OK;
                end
            endcase
        end
    end

    dep_chain #(
        .CAPACITY (CAPACITY),
        .DESCEND  (1'b0)
    ) u_asc (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (asc_ctrl),
        .ins_value  (value),
        .head_value (min_value),
        .head_valid (not_empty),
        .tail_valid (full)
    );

    // mirror row keeps the maximum at its head
    dep_chain #(
        .CAPACITY (CAPACITY),
        .DESCEND  (1'b1)
    ) u_desc (
        .clk        (clk),
        .rst_n      (rst_n),
        .ctrl       (desc_ctrl),
        .ins_value  (value),
        .head_value (max_value),
        .head_valid (),
        .tail_valid ()
    );

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg <= '0;
            done_reg  <= 1'b0;
        end
        else
        begin
            count_reg <= count_next;
            done_reg  <= accept;
        end
    end

    always_ff @(posedge clk)
    begin
        status_reg <= status_next;
        result_reg <= result_next;
    end

    assign done         = done_reg;
    assign status       = status_reg;
    assign result_value = result_reg;
    assign count        = COUNT_W'(count_reg);

endmodule

`default_nettype wire

FILE: src/dep_cell.sv
// ----------------------------------------------------------------------------
// dep_cell
// one slot of a sorted chain: value and valid, moves with its neighbours
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dep_cell #(
    parameter bit DESCEND = 1'b0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dep_pkg::cell_ctrl_t               ctrl,
    input  wire logic signed [dep_pkg::DATA_W-1:0] ins_value,
    input  wire logic                              left_take,
    input  wire logic signed [dep_pkg::DATA_W-1:0] left_value,
    input  wire logic                              left_valid,
    input  wire logic signed [dep_pkg::DATA_W-1:0] right_value,
    input  wire logic                              right_valid,
    output logic                                   take,
    output logic signed [dep_pkg::DATA_W-1:0]      value,
    output logic                                   valid
);
    import dep_pkg::*;

    logic signed [DATA_W-1:0] value_reg;
    logic signed [DATA_W-1:0] value_next;
    logic                     valid_reg;
    logic                     valid_next;
    logic                     beyond;

    // new element lands in the first slot that is empty or ranks after it
    assign beyond = DESCEND ? (value_reg < ins_value) : (value_reg > ins_value);
    assign take   = !valid_reg || beyond;

    always_comb
    begin
        value_next = value_reg;
        valid_next = valid_reg;
        if (ctrl.clr)
        begin
            valid_next = 1'b0;
        end
        else if (ctrl.ins)
        begin
            if (left_take)
            begin
                value_next = left_value;
                valid_next = left_valid;
            end
            else if (take)
            begin
                value_next = ins_value;
                valid_next = 1'b1;
            end
        end
        else if (ctrl.shift_down)
        begin
            value_next = right_value;
            valid_next = right_valid;
        end
        else if (ctrl.drop_top)
        begin
            valid_next = valid_reg && right_valid;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        value_reg <= value_next;
    end

    assign value = value_reg;
    assign valid = valid_reg;

endmodule

`default_nettype wire

FILE: src/dep_chain.sv
// ----------------------------------------------------------------------------
// dep_chain
// row of cells kept sorted, head holds the extreme element
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module dep_chain #(
    parameter int unsigned CAPACITY = 64,
    parameter bit          DESCEND  = 1'b0
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire dep_pkg::cell_ctrl_t               ctrl,
    input  wire logic signed [dep_pkg::DATA_W-1:0] ins_value,
    output logic signed [dep_pkg::DATA_W-1:0]      head_value,
    output logic                                   head_valid,
    output logic                                   tail_valid
);
    import dep_pkg::*;

    // padded neighbour links: index i+1 is cell i
    logic [CAPACITY:0]        take_link;
    logic [CAPACITY+1:0]      valid_link;
    logic signed [DATA_W-1:0] value_link [0:CAPACITY+1];

    assign take_link[0]           = 1'b0;
    assign valid_link[0]          = 1'b1;
    assign valid_link[CAPACITY+1] = 1'b0;
    assign value_link[0]          = '0;
    assign value_link[CAPACITY+1] = '0;

    for (genvar i = 0; i < CAPACITY; i++)
    begin : g_cell
        dep_cell #(
            .DESCEND (DESCEND)
        ) u_cell (
            .clk         (clk),
            .rst_n       (rst_n),
            .ctrl        (ctrl),
            .ins_value   (ins_value),
            .left_take   (take_link[i]),
            .left_value  (value_link[i]),
            .left_valid  (valid_link[i]),
            .right_value (value_link[i+2]),
            .right_valid (valid_link[i+2]),
            .take        (take_link[i+1]),
            .value       (value_link[i+1]),
            .valid       (valid_link[i+1])
        );
    end

    assign head_value = value_link[1];
    assign head_valid = valid_link[1];
    assign tail_valid = valid_link[CAPACITY];

endmodule

`default_nettype wire

FILE: src/dep_checker.sv
// ----------------------------------------------------------------------------
// dep_checker
// port-level checks on request and result timing and on status for the core
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "double_ended_priority_queue_core_assert.svh"

module dep_checker (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              start,
    input  wire logic                              busy,
    input  wire logic [dep_pkg::CMD_W-1:0]         command,
    input  wire logic                              done,
    input  wire logic [dep_pkg::STATUS_W-1:0]      status,
    input  wire logic signed [dep_pkg::DATA_W-1:0] result_value,
    input  wire logic [dep_pkg::COUNT_W-1:0]       count
);
    import dep_pkg::*;

    // every request answers on the next cycle
    `DEP_ASSERT_NEXT(a_req_done, start && !busy, done)
    // no result without a request
    `DEP_ASSERT_NOW(a_done_req, done, $past(start && !busy))
    // an empty error means nothing stored and no value
    `DEP_ASSERT_NOW(a_empty, done && status == ST_EMPTY, result_value == '0 && count == '0)
    // full is reported only for an insert
    `DEP_ASSERT_NOW(a_full_ins, done && status == ST_FULL, $past(command) == CMD_INSERT)
    // clear leaves an empty queue
    `DEP_ASSERT_NEXT(a_clear, start && !busy && command == CMD_CLEAR, status == ST_OK && count == '0)

endmodule

bind double_ended_priority_queue_core dep_checker u_dep_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .start        (start),
    .busy         (busy),
    .command      (command),
    .done         (done),
    .status       (status),
    .result_value (result_value),
    .count        (count)
);

`default_nettype wire

FILE: tb/sv/tb.sv
// ----------------------------------------------------------------------------
// tb
// self-checking bench for the double-ended priority queue core: a sorted
// shadow copy of the store predicts status, value and count per request
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;

    import dep_pkg::*;

    localparam int CAPACITY  = 64;
    localparam int RUN_LIMIT = 200000;
    // the one command code the block leaves unused
    localparam logic [CMD_W-1:0] CMD_UNUSED = 3'd7;

    typedef struct {
        status_t                    status;
        logic signed [DATA_W-1:0]   value;
        logic [COUNT_W-1:0]         count;
    } queue_reply_t;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       start = 1'b0;
    logic [CMD_W-1:0]           command = '0;
    logic signed [DATA_W-1:0]   value = '0;
    logic                       busy;
    logic                       done;
    logic [STATUS_W-1:0]        status;
    logic signed [DATA_W-1:0]   result_value;
    logic [COUNT_W-1:0]         count;

    // shadow store, ascending, and replies still to come
    logic signed [DATA_W-1:0]   shadow_store[$];
    queue_reply_t               replies_due[$];

    int mismatches = 0;
    int requests_sent = 0;
    int full_rejects = 0;
    int empty_rejects = 0;
    int peak_fill = 0;
    int cycles = 0;
    bit no_idle = 1'b0;

    double_ended_priority_queue_core #(
        .CAPACITY(CAPACITY)
    ) uut (
        .clk(clk),
        .rst_n(rst_n),
        .start(start),
        .busy(busy),
        .command(command),
        .value(value),
        .done(done),
        .status(status),
        .result_value(result_value),
        .count(count)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > RUN_LIMIT)
        begin
            $display("timeout after %0d cycles", cycles);
            $display("Mismatches found");
            $finish;
        end
    end

    function automatic queue_reply_t apply_request(input logic [CMD_W-1:0] cmd,
                                                   input logic signed [DATA_W-1:0] v);
        queue_reply_t r;
        int pos;
        r.status = ST_OK;
        r.value  = '0;
        case (cmd)
            CMD_INSERT:
            begin
                if (shadow_store.size() >= CAPACITY)
                begin
                    r.status = ST_FULL;
                    full_rejects++;
                end
                else
                begin
                    // equal values: the newcomer goes above those already held
                    pos = 0;
                    while (pos < shadow_store.size() && shadow_store[pos] <= v)
                        pos++;
                    shadow_store.insert(pos, v);
                end
            end
            CMD_EXT_MIN, CMD_EXT_MAX, CMD_PEEK_MIN, CMD_PEEK_MAX:
            begin
                if (shadow_store.size() == 0)
                begin
                    r.status = ST_EMPTY;
                    empty_rejects++;
                end
                else if (cmd == CMD_EXT_MIN)
                    r.value = shadow_store.pop_front();
                else if (cmd == CMD_EXT_MAX)
                begin
                    r.value = shadow_store[shadow_store.size() - 1];
                    shadow_store.delete(shadow_store.size() - 1);
                end
                else if (cmd == CMD_PEEK_MIN)
                    r.value = shadow_store[0];
                else
                    r.value = shadow_store[shadow_store.size() - 1];
            end
            CMD_CLEAR:
                shadow_store.delete();
            default:
                ;
        endcase
        if (shadow_store.size() > peak_fill)
            peak_fill = shadow_store.size();
        r.count = COUNT_W'(shadow_store.size());
        return r;
    endfunction

    // predict on every accepted request, then check whatever comes out
    always @(posedge clk)
    begin
        queue_reply_t want;
        if (rst_n && start && !busy)
            replies_due.insert(replies_due.size(), apply_request(command, value));
        if (rst_n && done)
        begin
            if (replies_due.size() == 0)
            begin
                $error("result with no request outstanding");
                mismatches++;
            end
            else
            begin
                want = replies_due.pop_front();
                if (status !== want.status)
                begin
                    $error("status: expected %0d, got %0d", want.status, status);
                    mismatches++;
                end
                if (result_value !== want.value)
                begin
                    $error("result_value: expected %0d, got %0d", want.value, result_value);
                    mismatches++;
                end
                if (count !== want.count)
                begin
                    $error("count: expected %0d, got %0d", want.count, count);
                    mismatches++;
                end
            end
        end
    end

    function automatic int pick_gap();
        int r;
        if (no_idle)
            return 0;
        r = $urandom_range(0, 99);
        if (r < 60)
            return 0;
        if (r < 93)
            return $urandom_range(1, 3);
        return $urandom_range(8, 40);
    endfunction

    function automatic logic signed [DATA_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0:
            begin
                case ($urandom_range(0, 3))
                    0: return 32'sh8000_0000;
                    1: return 32'sh7fff_ffff;
                    2: return 32'sd0;
                    default: return -32'sd1;
                endcase
            end
            1, 2, 3: return $signed(32'($urandom_range(0, 16))) - 32'sd8;
            default: return $urandom;
        endcase
    endfunction

    function automatic logic [CMD_W-1:0] pick_command(input int insert_pct);
        int r;
        if ($urandom_range(0, 99) < insert_pct)
            return CMD_INSERT;
        r = $urandom_range(0, 99);
        if (r < 30)
            return CMD_EXT_MIN;
        if (r < 60)
            return CMD_EXT_MAX;
        if (r < 75)
            return CMD_PEEK_MIN;
        if (r < 90)
            return CMD_PEEK_MAX;
        if (r < 96)
            return CMD_SIZE;
        if (r < 98)
            return CMD_CLEAR;
        return CMD_UNUSED;
    endfunction

    // hold start until the request is taken, then, if a gap is given, drop start and idle through it
    task automatic send_request(input logic [CMD_W-1:0] cmd,
                                input logic signed [DATA_W-1:0] v,
                                input int gap);
        start   <= 1'b1;
        command <= cmd;
        value   <= v;
        @(posedge clk);
        while (busy)
            @(posedge clk);
        requests_sent++;
        if (gap > 0)
        begin
            start <= 1'b0;
            repeat (gap) @(posedge clk);
        end
    endtask

    task automatic test_empty_and_extremes();
        send_request(CMD_EXT_MIN, 32'sd11, pick_gap());
        send_request(CMD_EXT_MAX, -32'sd1, pick_gap());
        send_request(CMD_PEEK_MIN, 32'sh7fff_ffff, pick_gap());
        send_request(CMD_PEEK_MAX, 32'sh8000_0000, pick_gap());
        send_request(CMD_SIZE, $urandom, pick_gap());
        send_request(CMD_INSERT, 32'sh7fff_ffff, pick_gap());
        send_request(CMD_INSERT, 32'sh8000_0000, pick_gap());
        send_request(CMD_INSERT, 32'sd0, pick_gap());
        send_request(CMD_INSERT, -32'sd1, pick_gap());
        send_request(CMD_INSERT, 32'sd5, pick_gap());
        send_request(CMD_INSERT, 32'sd5, pick_gap());
        send_request(CMD_PEEK_MIN, $urandom, pick_gap());
        send_request(CMD_PEEK_MAX, $urandom, pick_gap());
        send_request(CMD_UNUSED, 32'sh7fff_ffff, pick_gap());
        send_request(CMD_SIZE, $urandom, pick_gap());
        send_request(CMD_EXT_MAX, $urandom, pick_gap());
        send_request(CMD_EXT_MIN, $urandom, pick_gap());
        send_request(CMD_EXT_MAX, $urandom, pick_gap());
        send_request(CMD_EXT_MIN, $urandom, pick_gap());
        send_request(CMD_CLEAR, $urandom, pick_gap());
        send_request(CMD_SIZE, 32'sd0, pick_gap());
        send_request(CMD_PEEK_MAX, $urandom, pick_gap());
    endtask

    task automatic test_fill_and_overflow();
        int i;
        for (int round = 0; round < 2; round++)
        begin
            no_idle = (round == 0);
            for (i = 0; i < CAPACITY; i++)
                send_request(CMD_INSERT, pick_value(), pick_gap());
            for (i = 0; i < 3; i++)
                send_request(CMD_INSERT, pick_value(), pick_gap());
            send_request(CMD_PEEK_MIN, $urandom, pick_gap());
            send_request(CMD_PEEK_MAX, $urandom, pick_gap());
            if (round == 0)
            begin
                // drain from both ends and run past empty
                for (i = 0; i < CAPACITY + 2; i++)
                    send_request($urandom_range(0, 1) ? CMD_EXT_MIN : CMD_EXT_MAX,
                                 $urandom, pick_gap());
            end
            else
            begin
                send_request(CMD_CLEAR, $urandom, pick_gap());
                send_request(CMD_EXT_MIN, $urandom, pick_gap());
            end
        end
        no_idle = 1'b0;
    endtask

    task automatic test_random_mix();
        int insert_pct;
        for (int phase = 0; phase < 13; phase++)
        begin
            case ($urandom_range(0, 3))
                0: insert_pct = 85;
                1: insert_pct = 50;
                2: insert_pct = 20;
                default: insert_pct = 62;
            endcase
            no_idle = ($urandom_range(0, 3) == 0);
            for (int n = 0; n < 100; n++)
                send_request(pick_command(insert_pct), pick_value(), pick_gap());
        end
        no_idle = 1'b0;
    endtask

    initial
    begin
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_empty_and_extremes();
        test_fill_and_overflow();
        test_random_mix();
        start <= 1'b0;
        while (replies_due.size() != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
        $display("%0d requests over all commands, store filled to %0d of %0d",
                 requests_sent, peak_fill, CAPACITY);
        $display("%0d inserts refused as full, %0d reads refused as empty",
                 full_rejects, empty_rejects);
        if (mismatches == 0)
            $display("No mismatches found");
        else
            $display("Mismatches found");
        $finish;
    end

endmodule

FILE: double_ended_priority_queue_core.f
+incdir+src
src/dep_pkg.sv
src/dep_cell.sv
src/dep_chain.sv
src/double_ended_priority_queue_core.sv
src/dep_checker.sv
tb/sv/tb.sv
